/* rtl/core/butterworth_mask_gain_defines.svh */
// butterworth_mask_gain_defines.svh
// Assertion macros shared by the Butterworth mask gain RTL.
// No dependencies; included by the files that carry checks.
`ifndef BUTTERWORTH_MASK_GAIN_DEFINES_SVH
`define BUTTERWORTH_MASK_GAIN_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define BMG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BMG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bmg_pkg.sv */
// bmg_pkg.sv
// Shared widths, constants, register indexes and pipeline control type
// for the Butterworth mask gain block. No dependencies.
`default_nettype none

package bmg_pkg;

  // Port and field widths
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int ORD_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Largest image dimension / cutoff honored
  localparam int MAX_DIM = 4096;

  // Distance and ratio formats
  localparam int SQ_W   = 2 * DIM_W;
  localparam int DIST_W = SQ_W + 1;
  localparam int R_FRAC = 16;
  localparam int R_W    = 40;
  localparam int RQ_W   = DIST_W + R_FRAC;
  localparam int HALF_W = R_W / 2;
  localparam int PROD_W = 2 * R_W;

  localparam logic [R_W-1:0] R_SAT = '1;
  localparam logic [R_W-1:0] R_ONE = R_W'(1) << R_FRAC;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 3'd4;

  // Reset values
  localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [DIM_W-1:0] RST_CUTOFF = 13'd30;
  localparam logic [ORD_W-1:0] RST_ORDER  = 6'd2;

  // Control traveling with each item: valid plus high-pass center flag
  typedef struct packed {
    logic valid;
    logic zero;
  } bmg_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/bmg_dist.sv */
// bmg_dist.sv
// Front end: squared doubled distance to the center and cutoff, three stages.
// Depends on bmg_pkg and butterworth_mask_gain_defines.svh.
`default_nettype none
`include "butterworth_mask_gain_defines.svh"

module bmg_dist (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire  [bmg_pkg::COORD_W-1:0]  in_row,
  input  wire  [bmg_pkg::COORD_W-1:0]  in_col,
  input  wire                          mode,
  input  wire  [bmg_pkg::DIM_W-1:0]    img_w,
  input  wire  [bmg_pkg::DIM_W-1:0]    img_h,
  input  wire  [bmg_pkg::DIM_W-1:0]    cut_d0,
  output bmg_pkg::bmg_ctl_t            out_ctl,
  output logic [bmg_pkg::DIST_W-1:0]   out_num,
  output logic [bmg_pkg::DIST_W-1:0]   out_den
);

  localparam int DIM_W  = bmg_pkg::DIM_W;
  localparam int SQ_W   = bmg_pkg::SQ_W;
  localparam int DIST_W = bmg_pkg::DIST_W;

  logic [DIM_W-1:0]  two_row, two_col, dy_nxt, dx_nxt;
  logic [DIM_W-1:0]  dy_r, dx_r, d0_r;
  logic              v1_r, v2_r;
  logic [SQ_W-1:0]   sqy_r, sqx_r, d0sq_r;
  logic [DIST_W-1:0] dist_nxt, cut_nxt;
  bmg_pkg::bmg_ctl_t ctl_r;
  logic [DIST_W-1:0] num_r, den_r;

  // Stage 1: absolute offsets in doubled coordinates
  assign two_row = {in_row, 1'b0};
  assign two_col = {in_col, 1'b0};
  assign dy_nxt  = (img_h >= two_row) ? img_h - two_row : two_row - img_h;
  assign dx_nxt  = (img_w >= two_col) ? img_w - two_col : two_col - img_w;

  // Stage 3: sum, cutoff and mode swap
  assign dist_nxt = DIST_W'(sqy_r) + DIST_W'(sqx_r);
  assign cut_nxt  = DIST_W'({d0sq_r, 2'b00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      ctl_r <= '0;
    end else begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      ctl_r.valid <= v2_r;
      ctl_r.zero  <= mode && (dist_nxt == '0);
    end
    dy_r   <= dy_nxt;
    dx_r   <= dx_nxt;
    d0_r   <= cut_d0;
    sqy_r  <= dy_r * dy_r;
    sqx_r  <= dx_r * dx_r;
    d0sq_r <= d0_r * d0_r;
    num_r  <= mode ? cut_nxt : dist_nxt;
    den_r  <= mode ? dist_nxt : cut_nxt;
  end

  assign out_ctl = ctl_r;
  assign out_num = num_r;
  assign out_den = den_r;

  // Center flag only arises for high-pass items
  `BMG_ASSERT_IMP(a_zero_hp, clk, rst_n, ctl_r.valid && ctl_r.zero, mode, "zero flag in low-pass")

endmodule

`default_nettype wire

/* rtl/core/bmg_div.sv */
// bmg_div.sv
// Pipelined restoring divider, one quotient bit per stage, NUM_W stages.
// Depends on bmg_pkg.
`default_nettype none

module bmg_div #(
  parameter int NUM_W = 43,
  parameter int DEN_W = 27
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  bmg_pkg::bmg_ctl_t   in_ctl,
  input  wire  [NUM_W-1:0]    in_num,
  input  wire  [DEN_W-1:0]    in_den,
  output bmg_pkg::bmg_ctl_t   out_ctl,
  output logic [NUM_W-1:0]    out_quo
);

  bmg_pkg::bmg_ctl_t ctl_r   [NUM_W];
  logic [NUM_W-1:0]  num_r   [NUM_W];
  logic [DEN_W-1:0]  rem_r   [NUM_W];
  logic [DEN_W-1:0]  den_r   [NUM_W];
  logic [NUM_W-1:0]  num_i   [NUM_W];
  logic [DEN_W-1:0]  rem_i   [NUM_W];
  logic [DEN_W-1:0]  den_i   [NUM_W];
  logic [DEN_W:0]    trial   [NUM_W];
  logic              ge      [NUM_W];
  logic [NUM_W-1:0]  num_nxt [NUM_W];
  logic [DEN_W-1:0]  rem_nxt [NUM_W];

  // One trial subtract per stage; quotient bits shift in behind the dividend
  always_comb begin
    num_i[0] = in_num;
    rem_i[0] = '0;
    den_i[0] = in_den;
    for (int s = 1; s < NUM_W; s++) begin
      num_i[s] = num_r[s-1];
      rem_i[s] = rem_r[s-1];
      den_i[s] = den_r[s-1];
    end
    for (int s = 0; s < NUM_W; s++) begin
      trial[s]   = {rem_i[s], num_i[s][NUM_W-1]};
      ge[s]      = trial[s] >= {1'b0, den_i[s]};
      num_nxt[s] = {num_i[s][NUM_W-2:0], ge[s]};
      rem_nxt[s] = ge[s] ? DEN_W'(trial[s] - {1'b0, den_i[s]}) : trial[s][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_W; s++) begin
        ctl_r[s] <= '0;
      end
    end else begin
      ctl_r[0] <= in_ctl;
      for (int s = 1; s < NUM_W; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
    end
    for (int s = 0; s < NUM_W; s++) begin
      num_r[s] <= num_nxt[s];
      rem_r[s] <= rem_nxt[s];
      den_r[s] <= den_i[s];
    end
  end

  assign out_ctl = ctl_r[NUM_W-1];
  assign out_quo = num_r[NUM_W-1];

endmodule

`default_nettype wire

/* rtl/core/bmg_pow.sv */
// bmg_pow.sv
// Saturating fixed-point power r^n, two stages per multiplication step.
// Depends on bmg_pkg.
`default_nettype none

module bmg_pow #(
  parameter int STEPS = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  bmg_pkg::bmg_ctl_t           in_ctl,
  input  wire  [bmg_pkg::R_W-1:0]     in_r,
  input  wire  [bmg_pkg::ORD_W-1:0]   order,
  output bmg_pkg::bmg_ctl_t           out_ctl,
  output logic [bmg_pkg::R_W-1:0]     out_p
);

  localparam int R_W    = bmg_pkg::R_W;
  localparam int HALF_W = bmg_pkg::HALF_W;
  localparam int PROD_W = bmg_pkg::PROD_W;
  localparam int R_FRAC = bmg_pkg::R_FRAC;
  localparam int ORD_W  = bmg_pkg::ORD_W;

  bmg_pkg::bmg_ctl_t ctl_i   [STEPS];
  logic [R_W-1:0]    p_i     [STEPS];
  logic [R_W-1:0]    r_i     [STEPS];
  bmg_pkg::bmg_ctl_t ctl_a_r [STEPS];
  logic [R_W-1:0]    p_a_r   [STEPS];
  logic [R_W-1:0]    r_a_r   [STEPS];
  logic [R_W-1:0]    pp_ll_r [STEPS];
  logic [R_W-1:0]    pp_lh_r [STEPS];
  logic [R_W-1:0]    pp_hl_r [STEPS];
  logic [R_W-1:0]    pp_hh_r [STEPS];
  logic [PROD_W-1:0] prod    [STEPS];
  logic [R_W-1:0]    p_nxt   [STEPS];
  bmg_pkg::bmg_ctl_t ctl_b_r [STEPS];
  logic [R_W-1:0]    p_b_r   [STEPS];
  logic [R_W-1:0]    r_b_r   [STEPS];

  // Step inputs: first step starts from 1.0
  always_comb begin
    ctl_i[0] = in_ctl;
    p_i[0]   = bmg_pkg::R_ONE;
    r_i[0]   = in_r;
    for (int k = 1; k < STEPS; k++) begin
      ctl_i[k] = ctl_b_r[k-1];
      p_i[k]   = p_b_r[k-1];
      r_i[k]   = r_b_r[k-1];
    end
  end

  // Recombine partial products, saturate, skip steps beyond the order
  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      prod[k] = (PROD_W'(pp_hh_r[k]) << (2 * HALF_W))
              + ((PROD_W'(pp_hl_r[k]) + PROD_W'(pp_lh_r[k])) << HALF_W)
              + PROD_W'(pp_ll_r[k]);
      if ((ORD_W+1)'(k) < {1'b0, order}) begin
        if (|prod[k][PROD_W-1:R_W+R_FRAC]) begin
          p_nxt[k] = bmg_pkg::R_SAT;
        end else begin
          p_nxt[k] = prod[k][R_W+R_FRAC-1:R_FRAC];
        end
      end else begin
        p_nxt[k] = p_a_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STEPS; k++) begin
        ctl_a_r[k] <= '0;
        ctl_b_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < STEPS; k++) begin
        ctl_a_r[k] <= ctl_i[k];
        ctl_b_r[k] <= ctl_a_r[k];
      end
    end
    for (int k = 0; k < STEPS; k++) begin
      p_a_r[k]   <= p_i[k];
      r_a_r[k]   <= r_i[k];
      pp_ll_r[k] <= p_i[k][HALF_W-1:0] * r_i[k][HALF_W-1:0];
      pp_lh_r[k] <= p_i[k][HALF_W-1:0] * r_i[k][R_W-1:HALF_W];
      pp_hl_r[k] <= p_i[k][R_W-1:HALF_W] * r_i[k][HALF_W-1:0];
      pp_hh_r[k] <= p_i[k][R_W-1:HALF_W] * r_i[k][R_W-1:HALF_W];
      p_b_r[k]   <= p_nxt[k];
      r_b_r[k]   <= r_a_r[k];
    end
  end

  assign out_ctl = ctl_b_r[STEPS-1];
  assign out_p   = p_b_r[STEPS-1];

endmodule

`default_nettype wire

/* rtl/core/butterworth_mask_gain.sv */
// butterworth_mask_gain.sv
// Top level: configuration registers, distance front end, ratio divider,
// power chain and gain divider. Depends on bmg_pkg, bmg_dist, bmg_div, bmg_pow.
//
// Usage:
//   Input items: raise start with in_row_index / in_col_index; an item is
//   taken at each rising edge where start is high and busy is low. Busy is
//   cleared by the first edge after reset, so one item per cycle is sustained.
//   Results: out_gain is valid for one cycle while out_valid is high, one
//   result per item, in input order. Gain is unsigned Q1.GAIN_FRAC_BITS.
//   Path: distance front end, ratio divider, r saturation register, power
//   chain, gain operand register, gain divider (FN_W-bit dividend, 41 by
//   default) and output register. Both dividers resolve one bit per stage;
//   each multiply step of the power chain has two stages.
//   Configuration: cfg_we with cfg_index / cfg_wdata writes one register
//   in the cycle; write only while no item is in flight.
//   Reset (rst_n low, synchronous) clears all in-flight items and loads the
//   register defaults; busy stays high through reset.
//   The receiver has no back-pressure; results are always delivered.
`default_nettype none
`include "butterworth_mask_gain_defines.svh"

module butterworth_mask_gain #(
  parameter int MAX_ORDER      = 32,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire  [bmg_pkg::COORD_W-1:0]     in_row_index,
  input  wire  [bmg_pkg::COORD_W-1:0]     in_col_index,
  output logic                            out_valid,
  output logic [GAIN_FRAC_BITS:0]         out_gain,
  input  wire                             cfg_we,
  input  wire  [bmg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [bmg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DIM_W  = bmg_pkg::DIM_W;
  localparam int ORD_W  = bmg_pkg::ORD_W;
  localparam int DIST_W = bmg_pkg::DIST_W;
  localparam int RQ_W   = bmg_pkg::RQ_W;
  localparam int R_W    = bmg_pkg::R_W;
  localparam int R_FRAC = bmg_pkg::R_FRAC;
  localparam int DEN_W  = R_W + 1;
  localparam int FN_W   = ((GAIN_FRAC_BITS + R_FRAC > R_W) ?
                           GAIN_FRAC_BITS + R_FRAC : R_W) + 1;
  localparam int LAT    = 3 + RQ_W + 1 + 2 * MAX_ORDER + 1 + FN_W + 1;

  // Configuration registers
  logic              mode_r;
  logic [DIM_W-1:0]  width_r, height_r, cutoff_r;
  logic [ORD_W-1:0]  order_r;
  logic              busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= bmg_pkg::RST_WIDTH;
      height_r <= bmg_pkg::RST_HEIGHT;
      cutoff_r <= bmg_pkg::RST_CUTOFF;
      order_r  <= bmg_pkg::RST_ORDER;
      busy_r   <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          bmg_pkg::CFG_MODE:   mode_r   <= cfg_wdata[0];
          bmg_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
          bmg_pkg::CFG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
          bmg_pkg::CFG_CUTOFF: cutoff_r <= cfg_wdata[DIM_W-1:0];
          bmg_pkg::CFG_ORDER:  order_r  <= cfg_wdata[ORD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r | !rst_n;

  // Clamped register views
  logic [DIM_W-1:0] width_c, height_c, cut_clamp, cutoff_c;
  logic [ORD_W-1:0] order_c;

  assign width_c   = (width_r > DIM_W'(bmg_pkg::MAX_DIM)) ? DIM_W'(bmg_pkg::MAX_DIM) : width_r;
  assign height_c  = (height_r > DIM_W'(bmg_pkg::MAX_DIM)) ?
                     DIM_W'(bmg_pkg::MAX_DIM) : height_r;
  assign cut_clamp = (cutoff_r > DIM_W'(bmg_pkg::MAX_DIM)) ?
                     DIM_W'(bmg_pkg::MAX_DIM) : cutoff_r;
  assign cutoff_c  = (cut_clamp == '0) ? DIM_W'(1) : cut_clamp;
  assign order_c   = ({1'b0, order_r} > (ORD_W+1)'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : order_r;

  // Distance front end
  bmg_pkg::bmg_ctl_t dist_ctl;
  logic [DIST_W-1:0] dist_num, dist_den;

  bmg_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start && !busy),
    .in_row  (in_row_index),
    .in_col  (in_col_index),
    .mode    (mode_r),
    .img_w   (width_c),
    .img_h   (height_c),
    .cut_d0  (cutoff_c),
    .out_ctl (dist_ctl),
    .out_num (dist_num),
    .out_den (dist_den)
  );

  // Ratio r = num * 2^16 / den
  bmg_pkg::bmg_ctl_t rq_ctl;
  logic [RQ_W-1:0]   rq_quo;

  bmg_div #(.NUM_W(RQ_W), .DEN_W(DIST_W)) u_rdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ctl (dist_ctl),
    .in_num ({dist_num, R_FRAC'(0)}),
    .in_den (dist_den),
    .out_ctl(rq_ctl),
    .out_quo(rq_quo)
  );

  // Saturate r to Q24.16
  bmg_pkg::bmg_ctl_t r_ctl_r;
  logic [R_W-1:0]    r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_ctl_r <= '0;
    end else begin
      r_ctl_r <= rq_ctl;
    end
    r_r <= (|rq_quo[RQ_W-1:R_W]) ? bmg_pkg::R_SAT : rq_quo[R_W-1:0];
  end

  // r^n
  bmg_pkg::bmg_ctl_t pw_ctl;
  logic [R_W-1:0]    pw_p;

  bmg_pow #(.STEPS(MAX_ORDER)) u_pow (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ctl (r_ctl_r),
    .in_r   (r_r),
    .order  (order_c),
    .out_ctl(pw_ctl),
    .out_p  (pw_p)
  );

  // Gain dividend and divisor with round-half-up
  bmg_pkg::bmg_ctl_t gp_ctl_r;
  logic [DEN_W-1:0]  gden_nxt, gden_r;
  logic [FN_W-1:0]   gnum_r;

  assign gden_nxt = DEN_W'(pw_p) + DEN_W'(bmg_pkg::R_ONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_ctl_r <= '0;
    end else begin
      gp_ctl_r <= pw_ctl;
    end
    gden_r <= gden_nxt;
    gnum_r <= (FN_W'(1) << (GAIN_FRAC_BITS + R_FRAC)) + FN_W'(gden_nxt >> 1);
  end

  bmg_pkg::bmg_ctl_t gq_ctl;
  logic [FN_W-1:0]   gq_quo;

  bmg_div #(.NUM_W(FN_W), .DEN_W(DEN_W)) u_gdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ctl (gp_ctl_r),
    .in_num (gnum_r),
    .in_den (gden_r),
    .out_ctl(gq_ctl),
    .out_quo(gq_quo)
  );

  // Output register; high-pass center forces zero
  logic                    out_valid_r;
  logic [GAIN_FRAC_BITS:0] out_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= gq_ctl.valid;
    end
    out_gain_r <= gq_ctl.zero ? '0 : gq_quo[GAIN_FRAC_BITS:0];
  end

  assign out_valid = out_valid_r;
  assign out_gain  = out_gain_r;

  // Every accepted item comes out a fixed latency later, and only then
  `BMG_ASSERT_IMP(a_latency, clk, rst_n, 1'b1, out_valid_r == $past(start && !busy, LAT), "result latency mismatch")
  // Gain never exceeds 1.0
  `BMG_ASSERT_IMP(a_gain_max, clk, rst_n, out_valid_r, out_gain_r <= ((GAIN_FRAC_BITS+1)'(1) << GAIN_FRAC_BITS), "gain above one")

endmodule

`default_nettype wire

/* sim/butterworth_mask_gain_test.sv */
// butterworth_mask_gain_test.sv
// Self-checking testbench for butterworth_mask_gain: predicts every gain
// from the register settings and compares in order. Depends on bmg_pkg.
`timescale 1ns / 1ps

module butterworth_mask_gain_test;

  localparam int GF = 16;
  localparam int LAT = 160;
  localparam int WD_LIMIT = 4000;

  // Expected-gain store with its own copy of the registers
  class gain_scoreboard;
    logic [GF:0] gains[$];
    int errors = 0;
    bit [63:0] mode = 0, width = 640, height = 480, cutoff = 30, order = 2;

    function void set_reg(logic [bmg_pkg::CFG_IDX_W-1:0] idx,
                          logic [bmg_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        bmg_pkg::CFG_MODE:   mode = val & 1;
        bmg_pkg::CFG_WIDTH:  width = val;
        bmg_pkg::CFG_HEIGHT: height = val;
        bmg_pkg::CFG_CUTOFF: cutoff = val;
        bmg_pkg::CFG_ORDER:  order = val & 6'h3f;
        default: ;
      endcase
    endfunction

    function bit [63:0] clamp(bit [63:0] v, bit [63:0] hi);
      return v > hi ? hi : v;
    endfunction

    // Butterworth gain 1/(1+r^n) in Q1.16
    function logic [GF:0] butterworth_gain(bit [11:0] row, bit [11:0] col);
      bit [63:0] w, h, d0, n, dy, dx, dist4, cut4, r, p, den, g;
      w = clamp(width, bmg_pkg::MAX_DIM);
      h = clamp(height, bmg_pkg::MAX_DIM);
      d0 = clamp(cutoff, bmg_pkg::MAX_DIM);
      n = clamp(order, 32);
      if (d0 == 0) d0 = 1;
      dy = (h >= 2 * row) ? h - 2 * row : 2 * row - h;
      dx = (w >= 2 * col) ? w - 2 * col : 2 * col - w;
      dist4 = dy * dy + dx * dx;
      cut4 = 4 * d0 * d0;
      if (mode != 0) begin
        if (dist4 == 0) return '0;
        r = (cut4 << 16) / dist4;
      end else begin
        r = (dist4 << 16) / cut4;
      end
      if (r > 64'hff_ffff_ffff) r = 64'hff_ffff_ffff;
      p = 64'h1_0000;
      for (int k = 0; k < n; k++) begin
        if (r != 0 && p > (64'h00ff_ffff_ffff_ffff / r)) begin
          p = 64'hff_ffff_ffff;
        end else begin
          p = (p * r) >> 16;
          if (p > 64'hff_ffff_ffff) p = 64'hff_ffff_ffff;
        end
      end
      den = 64'h1_0000 + p;
      g = ((64'd1 << (GF + 16)) + (den >> 1)) / den;
      return g[GF:0];
    endfunction

    function void note(bit [11:0] row, bit [11:0] col);
      gains.push_back(butterworth_gain(row, col));
    endfunction

    function void check(logic [GF:0] got);
      logic [GF:0] want;
      if (gains.size() == 0) begin
        if (errors < 10) $display("unexpected gain %0d", got);
        errors++;
        return;
      end
      want = gains.pop_front();
      if (got !== want) begin
        if (errors < 10) $display("gain mismatch: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [bmg_pkg::COORD_W-1:0] in_row_index = '0;
  logic [bmg_pkg::COORD_W-1:0] in_col_index = '0;
  logic out_valid;
  logic [GF:0] out_gain;
  logic cfg_we = 0;
  logic [bmg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bmg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  gain_scoreboard sb = new();
  int idle_cycles = 0;

  always #6 clk = ~clk;

  butterworth_mask_gain DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .out_valid(out_valid), .out_gain(out_gain),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Monitor: accepted items, results, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note(in_row_index, in_col_index);
      if (out_valid) sb.check(out_gain);
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WD_LIMIT) begin
        $display("[butterworth_mask_gain] ERROR");
        $finish;
      end
    end
  end

  // Write all five registers back to back
  task automatic write_regs(int m, int w, int h, int c, int o);
    int vals[5];
    vals = '{m, w, h, c, o};
    cfg_we <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= bmg_pkg::CFG_IDX_W'(i);
      cfg_wdata <= bmg_pkg::CFG_DATA_W'(vals[i]);
      sb.set_reg(bmg_pkg::CFG_IDX_W'(i), bmg_pkg::CFG_DATA_W'(vals[i]));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drive one item, holding start until the block takes it
  task automatic send_item(int row, int col, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_row_index <= bmg_pkg::COORD_W'(row);
    in_col_index <= bmg_pkg::COORD_W'(col);
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.gains.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  // Coordinate near the center or anywhere
  function automatic int pick_coord(int dim, int cut);
    int c, spread, v;
    if (dim > bmg_pkg::MAX_DIM) dim = bmg_pkg::MAX_DIM;
    if (cut > bmg_pkg::MAX_DIM) cut = bmg_pkg::MAX_DIM;
    if (cut == 0) cut = 1;
    if ($urandom_range(1, 0) == 0) return $urandom_range(4095, 0);
    c = dim / 2;
    spread = 3 * cut + 2;
    v = c - spread + $urandom_range(2 * spread, 0);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  int cfgs[8][5] = '{
    '{0, 640, 480, 30, 2},
    '{1, 640, 480, 30, 2},
    '{0, 2, 2, 1, 1},
    '{1, 4096, 4096, 4096, 32},
    '{0, 8191, 8191, 0, 63},
    '{1, 8191, 0, 8191, 0},
    '{0, 1001, 777, 200, 5},
    '{1, 333, 4000, 7, 17}
  };

  initial begin
    int gap;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 8; ph++) begin
      write_regs(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3], cfgs[ph][4]);
      // Directed corners, center and cutoff ring
      if (ph < 2) begin
        send_item(240, 320, 0);
        send_item(0, 0, 0);
        send_item(4095, 4095, 1);
        send_item(0, 4095, 0);
        send_item(4095, 0, 2);
        send_item(240, 350, 0);
        send_item(270, 320, 0);
        send_item(240, 290, 3);
        send_item(241, 320, 0);
        send_item(2730, 1365, 0);
        send_item(1365, 2730, 4);
      end
      for (int i = 0; i < 180; i++) begin
        gap = (ph % 3 == 0) ? 0 : $urandom_range(4, 0);
        if (ph == 3 && i == 90) begin
          drain();
        end
        send_item(pick_coord(cfgs[ph][2], cfgs[ph][3]),
                  pick_coord(cfgs[ph][1], cfgs[ph][3]), gap);
      end
      drain();
    end
    if (sb.errors == 0 && sb.gains.size() == 0) begin
      $display("[butterworth_mask_gain] OK");
    end else begin
      $display("[butterworth_mask_gain] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bmg_pkg.sv
rtl/core/bmg_dist.sv
rtl/core/bmg_div.sv
rtl/core/bmg_pow.sv
rtl/core/butterworth_mask_gain.sv
sim/butterworth_mask_gain_test.sv
